FILE: sv/kds_pkg.sv
package kds_pkg;

   localparam int DIGIT_COUNT = 12;
   localparam int KEY_POS     = 6;
   localparam int SWAP_PAIRS  = 6;
   localparam int KEY_COUNT   = 10;
   localparam int KEY_MOD     = 9;

   localparam logic ACTION_ENCODE = 1'b0;
   localparam logic ACTION_DECODE = 1'b1;

   typedef logic [3:0] digit_type;
   typedef digit_type [DIGIT_COUNT-1:0] digit_vec_type;
   typedef digit_vec_type [KEY_COUNT-1:0] shift_table_type;
   typedef logic [SWAP_PAIRS-1:0] [1:0] [3:0] swap_set_type;

   // Contents of one shifted item; an encode item is not yet permuted.
   typedef struct packed {
      logic          action;
      logic          bad;
      digit_vec_type digits;
   } stage_type;

   localparam digit_type [KEY_COUNT-1:0] SHIFT_TAB = {
      4'd4, 4'd1, 4'd6, 4'd5, 4'd9, 4'd7, 4'd2, 4'd8, 4'd3, 4'd0
   };

   // Pairs are listed from the last to the first, so entry 0 is the first pair.
   localparam swap_set_type SWAP_ONE = {
      {4'd8, 4'd10}, {4'd5, 4'd6}, {4'd4, 4'd11},
      {4'd2, 4'd7},  {4'd1, 4'd3}, {4'd0, 4'd9}
   };

   localparam swap_set_type SWAP_TWO = {
      {4'd9, 4'd11}, {4'd7, 4'd8}, {4'd6, 4'd10},
      {4'd2, 4'd3},  {4'd1, 4'd4}, {4'd0, 4'd5}
   };

   // Walk the key index for every key value once, at elaboration.
   function automatic shift_table_type build_shift_table();
      shift_table_type t;
      int idx;
      for (int k = 0; k < KEY_COUNT; k++) begin
         idx = k;
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            if (i == KEY_POS) begin
               t[k][i] = 4'd0;
            end else begin
               idx = (idx % KEY_MOD) + 1;
               t[k][i] = SHIFT_TAB[idx];
               idx = idx + i + 1;
            end
         end
      end
      return t;
   endfunction

   localparam shift_table_type SHIFT_TABLE = build_shift_table();

   // Shift amounts of every position for one key digit; keys above nine only
   // occur with a bad digit, whose result is discarded.
   function automatic digit_vec_type shift_row(input digit_type key);
      digit_vec_type row;
      row = '0;
      for (int k = 0; k < KEY_COUNT; k++) begin
         if (key == digit_type'(k)) begin
            row = SHIFT_TABLE[k];
         end
      end
      return row;
   endfunction

   // Apply the pairs of a swap set in order; this is wiring only.
   function automatic digit_vec_type apply_swaps(input digit_vec_type d,
                                                 input swap_set_type set);
      digit_vec_type r;
      digit_type     t;
      r = d;
      for (int p = 0; p < SWAP_PAIRS; p++) begin
         t              = r[set[p][1]];
         r[set[p][1]]   = r[set[p][0]];
         r[set[p][0]]   = t;
      end
      return r;
   endfunction

endpackage

FILE: sv/kds_lane.sv
module kds_lane
   import kds_pkg::*;
(
   input  logic      decode,
   input  digit_type digit,
   input  digit_type shift,
   output digit_type result
);

   logic [4:0] offset;
   logic [4:0] sum;

   // Decode adds the complement of the shift, so both directions share one adder.
   assign offset = decode ? (5'd10 - {1'b0, shift}) : {1'b0, shift};
   assign sum    = {1'b0, digit} + offset;

   // The sum stays below twenty, so one subtraction brings it back into range.
   assign result = (sum >= 5'd10) ? digit_type'(sum - 5'd10) : sum[3:0];

endmodule

FILE: sv/kds_merge.sv
module kds_merge
   import kds_pkg::*;
(
   input  stage_type     stage,
   output digit_vec_type digits_out
);

   digit_vec_type swapped;

   // Encode permutes after the shift; decode has already undone the swaps.
   always_comb begin
      swapped = apply_swaps(apply_swaps(stage.digits, SWAP_ONE), SWAP_TWO);
      if (stage.bad) begin
         digits_out = '0;
      end else if (stage.action == ACTION_ENCODE) begin
         digits_out = swapped;
      end else begin
         digits_out = stage.digits;
      end
   end

endmodule

FILE: sv/keyed_digit_scrambler_12.sv
// An input transfer is registered in the first stage, then in the output register.
// Throughput: one item per cycle while the output is not stalled; twelve digit
// lanes work side by side and a merge stage applies the encode permutation, so nothing iterates.
// A stalled output still lets one further item enter the first stage.
// Reset (synchronous, active high) empties both stages; data are not cleared.
module keyed_digit_scrambler_12
   import kds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [47:0] req_digits_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [47:0] rsp_digits_out,
   output logic        rsp_bad_digit
);

   digit_vec_type in_digits;
   digit_vec_type unswapped;
   digit_vec_type pre_shift;
   digit_vec_type shifts;
   digit_vec_type lane_out;
   digit_vec_type merged;
   logic          in_bad;
   logic          accept;
   logic          s1_advance;

   logic          s1_valid_ff, s1_valid_in;
   stage_type     s1_ff, s1_in;
   logic          rsp_valid_ff, rsp_valid_in;
   digit_vec_type rsp_digits_ff;
   logic          rsp_bad_ff;

   // Split the input word into digits and flag any nibble above nine.
   always_comb begin
      in_digits = req_digits_in;
      in_bad    = 1'b0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (in_digits[i] > 4'd9) begin
            in_bad = 1'b1;
         end
      end
   end

   // Decode undoes the swaps first, so its key is taken after that.
   assign unswapped = apply_swaps(apply_swaps(in_digits, SWAP_TWO), SWAP_ONE);
   assign pre_shift = (req_action == ACTION_DECODE) ? unswapped : in_digits;
   assign shifts    = shift_row(pre_shift[KEY_POS]);

   // One lane per digit; the key digit passes straight through.
   for (genvar g = 0; g < DIGIT_COUNT; g++) begin : gen_lane
      if (g == KEY_POS) begin : gen_key
         assign lane_out[g] = pre_shift[g];
      end else begin : gen_shift
         kds_lane u_lane (
            .decode (req_action == ACTION_DECODE),
            .digit  (pre_shift[g]),
            .shift  (shifts[g]),
            .result (lane_out[g])
         );
      end
   end

   kds_merge u_merge (
      .stage      (s1_ff),
      .digits_out (merged)
   );

   // Pipeline handshake: the first stage moves on whenever the output is free.
   assign s1_advance   = s1_valid_ff & ~(rsp_valid_ff & rsp_stall);
   assign req_stall    = s1_valid_ff & ~s1_advance;
   assign accept       = req_valid & ~req_stall;
   assign s1_valid_in  = accept | (s1_valid_ff & ~s1_advance);
   assign rsp_valid_in = s1_advance | (rsp_valid_ff & rsp_stall);
   assign s1_in        = '{action: req_action, bad: in_bad, digits: lane_out};

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load on each transfer into their stage.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_advance) begin
         rsp_digits_ff <= merged;
         rsp_bad_ff    <= s1_ff.bad;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digits_out = rsp_digits_ff;
   assign rsp_bad_digit  = rsp_bad_ff;

endmodule

FILE: test/scrambler_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the digit scrambler, works out the result of every
// input transfer and compares each result transfer with the oldest one owed.
module scrambler_checker
   import kds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_action,
   input  logic [47:0] req_digits_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [47:0] rsp_digits_out,
   input  logic        rsp_bad_digit,
   output int          fail_count,
   output int          pending_results
);

   // Shift amount per key index, index 0 in the lowest nibble.
   localparam logic [39:0] KEY_SHIFTS = {
      4'd4, 4'd1, 4'd6, 4'd5, 4'd9, 4'd7, 4'd2, 4'd8, 4'd3, 4'd0
   };

   // Each byte holds one pair of positions, the first pair in the lowest byte.
   localparam logic [47:0] FIRST_SWAPS = {
      4'd10, 4'd8, 4'd6, 4'd5, 4'd11, 4'd4, 4'd7, 4'd2, 4'd3, 4'd1, 4'd9, 4'd0
   };
   localparam logic [47:0] SECOND_SWAPS = {
      4'd11, 4'd9, 4'd8, 4'd7, 4'd10, 4'd6, 4'd3, 4'd2, 4'd4, 4'd1, 4'd5, 4'd0
   };

   localparam int KEY_DIGIT = 6;

   // Each entry holds the bad digit flag above the twelve digits.
   logic [48:0] owed_results [$];
   int          mismatches = 0;

   // Exchanges the digit positions named by one swap set.
   function automatic logic [47:0] swap_positions(input logic [47:0] word,
                                                  input logic [47:0] pairs);
      logic [47:0] r;
      logic [3:0]  t;
      int          a;
      int          b;
      r = word;
      for (int p = 0; p < 6; p++) begin
         a = int'(pairs[8*p +: 4]);
         b = int'(pairs[8*p+4 +: 4]);
         t = r[4*a +: 4];
         r[4*a +: 4] = r[4*b +: 4];
         r[4*b +: 4] = t;
      end
      return r;
   endfunction

   // Adds or removes the keyed shift on every position except the key digit.
   function automatic logic [47:0] shift_positions(input logic [47:0] word,
                                                   input logic unshift);
      logic [47:0] r;
      int          idx;
      int          amount;
      int          digit;
      r   = word;
      idx = int'(r[4*KEY_DIGIT +: 4]);
      for (int i = 0; i < 12; i++) begin
         if (i != KEY_DIGIT) begin
            idx    = (idx % 9) + 1;
            amount = int'(KEY_SHIFTS[4*idx +: 4]);
            digit  = int'(r[4*i +: 4]);
            if (unshift) begin
               digit = (digit + 10 - amount) % 10;
            end else begin
               digit = (digit + amount) % 10;
            end
            r[4*i +: 4] = 4'(digit);
            idx = idx + i + 1;
         end
      end
      return r;
   endfunction

   // Result of one number: the flag on top, digits zero when the flag is set.
   function automatic logic [48:0] predict_digits(input logic action,
                                                  input logic [47:0] word);
      logic [47:0] r;
      logic        bad;
      bad = 1'b0;
      for (int i = 0; i < 12; i++) begin
         if (word[4*i +: 4] > 4'd9) begin
            bad = 1'b1;
         end
      end
      if (bad) begin
         return {1'b1, 48'h0};
      end
      if (action == ACTION_DECODE) begin
         r = swap_positions(word, SECOND_SWAPS);
         r = swap_positions(r, FIRST_SWAPS);
         r = shift_positions(r, 1'b1);
      end else begin
         r = shift_positions(word, 1'b0);
         r = swap_positions(r, FIRST_SWAPS);
         r = swap_positions(r, SECOND_SWAPS);
      end
      return {1'b0, r};
   endfunction

   // Results are matched before new work is queued, as a result never
   // belongs to an item taken at the same edge.
   always @(posedge clock) begin
      logic [48:0] owed;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               $error("result transfer with nothing owed: digits_out %h bad_digit %b",
                      rsp_digits_out, rsp_bad_digit);
               mismatches++;
            end else begin
               owed = owed_results.pop_front();
               if (rsp_digits_out !== owed[47:0]) begin
                  $error("digits_out mismatch: expected %h, actual %h",
                         owed[47:0], rsp_digits_out);
                  mismatches++;
               end
               if (rsp_bad_digit !== owed[48]) begin
                  $error("bad_digit mismatch: expected %b, actual %b",
                         owed[48], rsp_bad_digit);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            owed_results.push_back(predict_digits(req_action, req_digits_in));
         end
      end
      fail_count      <= mismatches;
      pending_results <= owed_results.size();
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

// Drives numbers into the digit scrambler in bursts against a stalling
// receiver; the checker beside the block judges every result.
module testbench
   import kds_pkg::*;
();

   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE_TIME  = 8;
   localparam int RANDOM_ITEMS = 1300;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_HALF,
      STALL_EVERY_FOURTH,
      STALL_HEAVY
   } stall_mode_type;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic        req_action    = ACTION_ENCODE;
   logic [47:0] req_digits_in = '0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [47:0] rsp_digits_out;
   logic        rsp_bad_digit;

   int             fail_count;
   int             pending_results;
   int             burst_left      = 0;
   int             idle_cycles     = 0;
   int             stall_mode_left = 0;
   logic [1:0]     stall_phase     = '0;
   stall_mode_type stall_mode      = STALL_NONE;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   keyed_digit_scrambler_12 u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_digits_in  (req_digits_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digits_out (rsp_digits_out),
      .rsp_bad_digit  (rsp_bad_digit)
   );

   scrambler_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_digits_in   (req_digits_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digits_out  (rsp_digits_out),
      .rsp_bad_digit   (rsp_bad_digit),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   // The receiver moves to a randomly chosen stall pattern when the current one runs out.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 2'd1;
      if (stall_mode_left == 0) begin
         stall_mode      <= stall_mode_type'($urandom_range(0, 3));
         stall_mode_left <= $urandom_range(64, 256);
      end else begin
         stall_mode_left <= stall_mode_left - 1;
      end
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_HALF: begin
            rsp_stall <= 1'($urandom_range(0, 1));
         end
         STALL_EVERY_FOURTH: begin
            rsp_stall <= (stall_phase == 2'd3);
         end
         default: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
      endcase
   end

   // The run is abandoned when no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [47:0] random_bcd();
      logic [47:0] word;
      for (int i = 0; i < 12; i++) begin
         word[4*i +: 4] = 4'($urandom_range(0, 9));
      end
      return word;
   endfunction

   function automatic logic random_action();
      return $urandom_range(0, 1) ? ACTION_DECODE : ACTION_ENCODE;
   endfunction

   // Offers one number and returns at the edge of its transfer. A gap of
   // random length may come first when the current burst is used up.
   task automatic send_number(input logic action, input logic [47:0] word);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 60);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_action    <= action;
      req_digits_in <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Holds the sender back until every owed result has been taken.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   initial begin
      logic [47:0] word;
      logic [63:0] raw;
      int          kind;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed numbers: extremes, every key digit and malformed digits.
      send_number(ACTION_ENCODE, 48'h0);
      send_number(ACTION_DECODE, 48'h0);
      send_number(ACTION_ENCODE, 48'h9999_9999_9999);
      send_number(ACTION_DECODE, 48'h9999_9999_9999);
      send_number(ACTION_ENCODE, 48'h1234_5678_9012);
      send_number(ACTION_DECODE, 48'h1234_5678_9012);
      for (int k = 0; k < 10; k++) begin
         word = random_bcd();
         word[27:24] = 4'(k);
         send_number(ACTION_ENCODE, word);
         word = random_bcd();
         word[27:24] = 4'(9 - k);
         if (k % 2 == 0) begin
            send_number(ACTION_DECODE, word);
         end
      end
      send_number(ACTION_ENCODE, 48'h9999_9999_999F);
      send_number(ACTION_DECODE, 48'hA999_9999_9999);
      send_number(ACTION_ENCODE, 48'h0000_00B0_0000);
      send_number(ACTION_DECODE, 48'hFFFF_FFFF_FFFF);
      drain_results();

      // Random numbers, mostly well formed, some with a malformed digit.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         kind = $urandom_range(0, 99);
         if (kind < 80) begin
            word = random_bcd();
         end else if (kind < 92) begin
            word = random_bcd();
            word[4*$urandom_range(0, 11) +: 4] = 4'($urandom_range(10, 15));
         end else begin
            raw  = {$urandom(), $urandom()};
            word = raw[47:0];
         end
         send_number(random_action(), word);
         if (n % 300 == 299) begin
            drain_results();
         end
      end

      drain_results();
      repeat (SETTLE_TIME) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
